[sv/lscc_pkg.sv]
`default_nettype none
package lscc_pkg;

    localparam int MAX_BEAMS_DEF = 2048;
    localparam int PI_Q          = 205887;
    localparam int TWO_PI_Q      = 2 * PI_Q;
    localparam int HALF_PI_Q     = 102944;
    localparam int NO_RANGE      = 141200;

    localparam int CFG_W = 20;
    localparam logic [2:0] CFG_BLIND      = 3'd0;
    localparam logic [2:0] CFG_RANGE_LOW  = 3'd1;
    localparam logic [2:0] CFG_RANGE_HIGH = 3'd2;
    localparam logic [2:0] CFG_SAFETY     = 3'd3;
    localparam logic [2:0] CFG_LOOK_AHEAD = 3'd4;
    localparam logic [2:0] CFG_START      = 3'd5;
    localparam logic [2:0] CFG_STEP       = 3'd6;

    typedef struct packed {
        logic [18:0]        blind_sector;
        logic [15:0]        range_low;
        logic [15:0]        range_high;
        logic [15:0]        safety_radius;
        logic [17:0]        look_ahead;
        logic signed [19:0] start_angle;
        logic [15:0]        angle_step;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic sqrt_mode;
    } t_unit_ctl;

    function automatic logic [16:0] asin_t(input logic [4:0] k);
        logic [16:0] v;
        case (k)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd2048;
            5'd2:    v = 17'd4099;
            5'd3:    v = 17'd6153;
            5'd4:    v = 17'd8213;
            5'd5:    v = 17'd10282;
            5'd6:    v = 17'd12361;
            5'd7:    v = 17'd14453;
            5'd8:    v = 17'd16560;
            5'd9:    v = 17'd18684;
            5'd10:   v = 17'd20829;
            5'd11:   v = 17'd22997;
            5'd12:   v = 17'd25192;
            5'd13:   v = 17'd27417;
            5'd14:   v = 17'd29676;
            5'd15:   v = 17'd31973;
            default: v = 17'd34315;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

[sv/lidar_scan_collision_cone.sv]
// channel   dir  handshake                 payload
// in        in   i_in_valid / o_in_stall   i_range_cm, i_heading_offset, i_last_sample
// out       out  o_out_valid / i_out_stall o_nearest_range, o_cone_upper, o_cone_lower,
//                                          o_collision
// cfg       in   i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A beam is skipped at the range and sector check, takes the saturated half angle, or
// goes through the divide and, when the ratio exceeds one half, the square root;
// one shift-subtract unit does both. The last beam of a scan then enters a finish state.
// Reset is synchronous, active low, and restores the scan state and config registers.
// A finished result waits in the output register while the next beam is taken; the last
// beam of a scan holds until that register is free.
`default_nettype none
module lidar_scan_collision_cone #(
    parameter int MAX_BEAMS = lscc_pkg::MAX_BEAMS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [2:0]                 i_cfg_idx,
    input  wire logic [lscc_pkg::CFG_W-1:0] i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_stall,
    input  wire logic [15:0]                i_range_cm,
    input  wire logic signed [19:0]         i_heading_offset,
    input  wire logic                       i_last_sample,
    output logic                            o_out_valid,
    input  wire logic                       i_out_stall,
    output logic [17:0]                     o_nearest_range,
    output logic signed [19:0]              o_cone_upper,
    output logic signed [19:0]              o_cone_lower,
    output logic                            o_collision
);
    import lscc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blind_sector  <= 19'd0;
            r_cfg.range_low     <= 16'd0;
            r_cfg.range_high    <= 16'd65535;
            r_cfg.safety_radius <= 16'd500;
            r_cfg.look_ahead    <= 18'd2000;
            r_cfg.start_angle   <= 20'sd0;
            r_cfg.angle_step    <= 16'd287;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLIND:      r_cfg.blind_sector  <= i_cfg_data[18:0];
                CFG_RANGE_LOW:  r_cfg.range_low     <= i_cfg_data[15:0];
                CFG_RANGE_HIGH: r_cfg.range_high    <= i_cfg_data[15:0];
                CFG_SAFETY:     r_cfg.safety_radius <= i_cfg_data[15:0];
                CFG_LOOK_AHEAD: r_cfg.look_ahead    <= i_cfg_data[17:0];
                CFG_START:      r_cfg.start_angle   <= $signed(i_cfg_data[19:0]);
                CFG_STEP:       r_cfg.angle_step    <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    lscc_core #(
        .MAX_BEAMS (MAX_BEAMS)
    ) u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_range_cm       (i_range_cm),
        .i_heading_offset (i_heading_offset),
        .i_last_sample    (i_last_sample),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_nearest_range  (o_nearest_range),
        .o_cone_upper     (o_cone_upper),
        .o_cone_lower     (o_cone_lower),
        .o_collision      (o_collision)
    );
endmodule
`default_nettype wire

[sv/lscc_unit.sv]
`default_nettype none
module lscc_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire lscc_pkg::t_unit_ctl i_ctl,
    input  wire logic [15:0]         i_dvd,
    input  wire logic [15:0]         i_dvs,
    input  wire logic [29:0]         i_rad,
    output logic                     o_done,
    output logic [15:0]              o_res
);
    import lscc_pkg::*;

    logic        r_busy;
    logic        r_done;
    logic        r_sqrt;
    logic [4:0]  r_cnt;
    logic [18:0] r_rem;
    logic [29:0] r_rad;
    logic [15:0] r_res;

    logic [18:0] sh;
    logic [18:0] trial;
    logic        ge;

    always_comb begin
        if (r_sqrt) begin
            sh    = {r_rem[16:0], r_rad[29:28]};
            trial = {1'b0, r_res, 2'b01};
        end else begin
            sh    = {r_rem[17:0], 1'b0};
            trial = {3'b000, i_dvs};
        end
        ge = (sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_sqrt <= i_ctl.sqrt_mode;
                r_cnt  <= i_ctl.sqrt_mode ? 5'd15 : 5'd16;
                r_rem  <= i_ctl.sqrt_mode ? 19'd0 : {3'b000, i_dvd};
                r_rad  <= i_rad;
                r_res  <= 16'd0;
            end else if (r_busy) begin
                r_rem <= ge ? (sh - trial) : sh;
                r_res <= {r_res[14:0], ge};
                r_rad <= {r_rad[27:0], 2'b00};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;
endmodule
`default_nettype wire

[sv/lscc_core.sv]
`default_nettype none
module lscc_core #(
    parameter int MAX_BEAMS = lscc_pkg::MAX_BEAMS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire lscc_pkg::t_cfg     i_cfg,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [15:0]        i_range_cm,
    input  wire logic signed [19:0] i_heading_offset,
    input  wire logic               i_last_sample,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [17:0]             o_nearest_range,
    output logic signed [19:0]      o_cone_upper,
    output logic signed [19:0]      o_cone_lower,
    output logic                    o_collision
);
    import lscc_pkg::*;

    localparam int IW = (MAX_BEAMS > 2) ? $clog2(MAX_BEAMS) : 1;
    localparam int PW = IW + 16;
    localparam int TW = IW + 18;
    localparam int CW = TW + 2;

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_MUL    = 9'b000000010,
        S_CHECK  = 9'b000000100,
        S_DIV    = 9'b000001000,
        S_SQRT   = 9'b000010000,
        S_INTERP = 9'b000100000,
        S_MU     = 9'b001000000,
        S_EDGE   = 9'b010000000,
        S_FINISH = 9'b100000000
    } t_state;

    t_state             r_state;
    logic [IW-1:0]      r_idx;
    logic [IW-1:0]      r_bidx;
    logic               r_first;
    logic [17:0]        r_near;
    logic signed [19:0] r_up;
    logic signed [19:0] r_lo;
    logic [15:0]        r_r;
    logic signed [19:0] r_off;
    logic               r_last;
    logic [PW-1:0]      r_prod;
    logic signed [19:0] r_theta;
    logic [15:0]        r_arg;
    logic               r_dbl;
    logic [22:0]        r_mul;
    logic [17:0]        r_mu;
    logic               r_ovalid;
    logic [17:0]        r_onear;
    logic signed [19:0] r_oup;
    logic signed [19:0] r_olo;
    logic               r_ohit;

    t_unit_ctl   ctl;
    logic        u_done;
    logic [15:0] u_res;

    logic                 accept;
    logic [IW:0]          idx_inc;
    logic signed [TW-1:0] theta;
    logic [TW-1:0]        mag;
    logic signed [CW-1:0] lim;
    logic                 counts;
    logic                 sat;
    logic [4:0]           k;
    logic [11:0]          dk;
    logic [16:0]          asin_a;
    logic signed [18:0]   mu_big;
    logic signed [20:0]   up_n;
    logic signed [20:0]   lo_n;
    logic signed [20:0]   hu;
    logic signed [20:0]   hl;
    logic                 out_free;

    lscc_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_dvd   (i_cfg.safety_radius),
        .i_dvs   (r_r),
        .i_rad   ({15'd0 - u_res[14:0], 15'd0}),
        .o_done  (u_done),
        .o_res   (u_res)
    );

    always_comb begin
        accept  = i_in_valid && (r_state == S_IDLE);
        idx_inc = {1'b0, r_idx} + (IW+1)'(1);
        theta   = -($signed({{(TW-20){i_cfg.start_angle[19]}}, i_cfg.start_angle})
                    + $signed({2'b00, r_prod}));
        mag     = theta[TW-1] ? TW'(-theta) : TW'(theta);
        lim     = $signed(CW'(TWO_PI_Q)) - $signed(CW'(i_cfg.blind_sector));
        counts  = !r_bidx[0] && ($signed({1'b0, mag, 1'b0}) < lim)
                  && (r_r > i_cfg.range_low) && (r_r < i_cfg.range_high);
        sat     = (r_r == 16'd0) || (i_cfg.safety_radius >= r_r);
        k       = r_arg[15:11];
        dk      = (k == 5'd16) ? 12'd0 : 12'(asin_t(k + 5'd1) - asin_t(k));
        asin_a  = asin_t(k) + 17'((r_mul + 23'd1024) >> 11);
        mu_big  = $signed(19'(HALF_PI_Q)) - $signed({1'b0, asin_a, 1'b0});
        up_n    = $signed({r_theta[19], r_theta}) + $signed({3'b000, r_mu});
        lo_n    = $signed({r_theta[19], r_theta}) - $signed({3'b000, r_mu});
        hu      = $signed({r_up[19], r_up}) - $signed({r_off[19], r_off});
        hl      = $signed({r_lo[19], r_lo}) - $signed({r_off[19], r_off});
        out_free = !r_ovalid || !i_out_stall;
        ctl.start     = 1'b0;
        ctl.sqrt_mode = 1'b0;
        if (r_state == S_CHECK && counts && !sat) begin
            ctl.start = 1'b1;
        end
        if (r_state == S_DIV && u_done && u_res > 16'd32768) begin
            ctl.start     = 1'b1;
            ctl.sqrt_mode = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_idx    <= '0;
            r_first  <= 1'b1;
            r_near   <= 18'(NO_RANGE);
            r_up     <= '0;
            r_lo     <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && !i_out_stall && r_state != S_FINISH) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_r    <= i_range_cm;
                        r_off  <= i_heading_offset;
                        r_last <= i_last_sample;
                        r_bidx <= r_idx;
                        r_idx  <= (idx_inc >= (IW+1)'(MAX_BEAMS)) ? '0 : idx_inc[IW-1:0];
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= PW'(r_bidx * i_cfg.angle_step);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_theta <= theta[19:0];
                    if (!counts) begin
                        r_state <= r_last ? S_FINISH : S_IDLE;
                    end else if (sat) begin
                        r_mu    <= 18'(HALF_PI_Q);
                        r_state <= S_EDGE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (u_done) begin
                        r_arg   <= u_res;
                        r_dbl   <= 1'b0;
                        r_state <= (u_res > 16'd32768) ? S_SQRT : S_INTERP;
                    end
                end
                S_SQRT: begin
                    if (u_done) begin
                        r_arg   <= u_res;
                        r_dbl   <= 1'b1;
                        r_state <= S_INTERP;
                    end
                end
                S_INTERP: begin
                    r_mul   <= dk * r_arg[10:0];
                    r_state <= S_MU;
                end
                S_MU: begin
                    r_mu    <= r_dbl ? 18'(mu_big) : {1'b0, asin_a};
                    r_state <= S_EDGE;
                end
                S_EDGE: begin
                    if (r_first || up_n > $signed({r_up[19], r_up})) begin
                        r_up <= up_n[19:0];
                    end
                    if (r_first || lo_n < $signed({r_lo[19], r_lo})) begin
                        r_lo <= lo_n[19:0];
                    end
                    r_first <= 1'b0;
                    if ({2'b00, r_r} < r_near) begin
                        r_near <= {2'b00, r_r};
                    end
                    r_state <= r_last ? S_FINISH : S_IDLE;
                end
                S_FINISH: begin
                    if (out_free) begin
                        r_ovalid <= 1'b1;
                        r_onear  <= r_near;
                        r_oup    <= r_up;
                        r_olo    <= r_lo;
                        r_ohit   <= (r_near < i_cfg.look_ahead) && (hu > 0) && (hl < 0);
                        r_idx    <= '0;
                        r_first  <= 1'b1;
                        r_near   <= 18'(NO_RANGE);
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_nearest_range = r_onear;
    assign o_cone_upper    = r_oup;
    assign o_cone_lower    = r_olo;
    assign o_collision     = r_ohit;
endmodule
`default_nettype wire

[sv/lscc_chk.sv]
`default_nettype none
module lscc_chk (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               i_in_valid,
    input wire logic               o_in_stall,
    input wire logic               o_out_valid,
    input wire logic               i_out_stall,
    input wire logic [17:0]        o_nearest_range,
    input wire logic signed [19:0] o_cone_upper,
    input wire logic signed [19:0] o_cone_lower
);
    import lscc_pkg::*;

    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a beam is in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_nearest_range))
        else $error("stalled result dropped or changed");

    a_cone_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_cone_upper >= o_cone_lower)
        else $error("cone edges inverted");

    a_near_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_nearest_range <= 18'(NO_RANGE))
        else $error("nearest range beyond sentinel");
endmodule

bind lidar_scan_collision_cone lscc_chk u_lscc_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_nearest_range (o_nearest_range),
    .o_cone_upper    (o_cone_upper),
    .o_cone_lower    (o_cone_lower)
);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import lscc_pkg::*;

    typedef struct packed {
        logic [17:0]        nearest;
        logic signed [19:0] upper;
        logic signed [19:0] lower;
        logic               hit;
    } t_scan;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = CFG_BLIND;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    logic [15:0] i_range_cm = '0;
    logic signed [19:0] i_heading_offset = '0;
    logic i_last_sample = 1'b0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [17:0] o_nearest_range;
    logic signed [19:0] o_cone_upper;
    logic signed [19:0] o_cone_lower;
    logic o_collision;

    lidar_scan_collision_cone uut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    t_cfg cfg;
    int beam_idx;
    bit first_beam;
    int nearest_cm;
    longint edge_hi, edge_lo;
    t_scan scans_due[$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    bit hold_recv = 1'b0;
    int quiet_cycles = 0;

    localparam int TAB[17] = '{0, 2048, 4099, 6153, 8213, 10282, 12361, 14453, 16560,
                               18684, 20829, 22997, 25192, 27417, 29676, 31973, 34315};

    function automatic longint asin_interp(longint q);
        longint k;
        longint f;
        k = q >> 11;
        f = q & 2047;
        if (k >= 16) return TAB[16];
        return TAB[k] + (((TAB[k+1] - TAB[k]) * f + 1024) >>> 11);
    endfunction

    function automatic longint int_sqrt(longint v);
        longint r;
        r = 0;
        while ((r + 1) * (r + 1) <= v) r++;
        return r;
    endfunction

    function automatic longint half_angle(longint r, longint rs);
        longint q;
        if (r == 0 || rs >= r) return HALF_PI_Q;
        q = (rs << 16) / r;
        if (q <= 32768) return asin_interp(q);
        return HALF_PI_Q - 2 * asin_interp(int_sqrt((65536 - q) * 32768));
    endfunction

    task automatic clear_model();
        cfg.blind_sector = 0;
        cfg.range_low = 0;
        cfg.range_high = 65535;
        cfg.safety_radius = 500;
        cfg.look_ahead = 2000;
        cfg.start_angle = 0;
        cfg.angle_step = 287;
        beam_idx = 0;
        first_beam = 1;
        nearest_cm = NO_RANGE;
        edge_hi = 0;
        edge_lo = 0;
    endtask

    task automatic predict_beam(logic [15:0] r, logic signed [19:0] off, logic last);
        longint theta, mag, mu;
        t_scan s;
        if (beam_idx % 2 == 0) begin
            theta = -(longint'(cfg.start_angle) + longint'(beam_idx) * cfg.angle_step);
            mag = theta < 0 ? -theta : theta;
            if (2 * mag < 2 * longint'(PI_Q) - longint'(cfg.blind_sector) &&
                    r > cfg.range_low && r < cfg.range_high) begin
                mu = half_angle(r, cfg.safety_radius);
                if (first_beam) begin
                    edge_hi = theta + mu;
                    edge_lo = theta - mu;
                    first_beam = 0;
                end
                if (theta + mu > edge_hi) edge_hi = theta + mu;
                if (theta - mu < edge_lo) edge_lo = theta - mu;
                if (r < nearest_cm) nearest_cm = r;
            end
        end
        beam_idx = (beam_idx + 1 >= MAX_BEAMS_DEF) ? 0 : beam_idx + 1;
        if (last) begin
            s.nearest = 18'(nearest_cm);
            s.upper = 20'(edge_hi);
            s.lower = 20'(edge_lo);
            s.hit = nearest_cm < cfg.look_ahead && edge_hi - off > 0 && edge_lo - off < 0;
            scans_due = {scans_due, s};
            beam_idx = 0;
            first_beam = 1;
            nearest_cm = NO_RANGE;
        end
    endtask

    task automatic write_reg(logic [2:0] idx, int val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_BLIND:      cfg.blind_sector = 19'(val);
            CFG_RANGE_LOW:  cfg.range_low = 16'(val);
            CFG_RANGE_HIGH: cfg.range_high = 16'(val);
            CFG_SAFETY:     cfg.safety_radius = 16'(val);
            CFG_LOOK_AHEAD: cfg.look_ahead = 18'(val);
            CFG_START:      cfg.start_angle = 20'(val);
            default:        cfg.angle_step = 16'(val);
        endcase
    endtask

    task automatic send_beam(logic [15:0] r, logic signed [19:0] off, logic last);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_in_valid = 1'b1;
        i_range_cm = r;
        i_heading_offset = off;
        i_last_sample = last;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_beam(r, off, last);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    task automatic drain();
        while (scans_due.size() != 0) @(negedge i_clk);
        repeat (60) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        i_out_stall <= hold_recv || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_scan e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scans_due.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected beat: %0d %0d %0d %0d",
                    o_nearest_range, o_cone_upper, o_cone_lower, o_collision);
            end else begin
                e = scans_due.pop_front();
                if (e !== {o_nearest_range, o_cone_upper, o_cone_lower, o_collision}) begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                            e.nearest, e.upper, e.lower, e.hit, o_nearest_range,
                            o_cone_upper, o_cone_lower, o_collision);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 200000) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic logic signed [19:0] rand_off();
        return $urandom_range(3) == 0 ? 20'($urandom) : 20'($signed($urandom_range(8000)) - 4000);
    endfunction

    task automatic test_directed();
        send_beam(16'd1000, 20'sd0, 1'b1);
        send_beam(16'd0, 20'sd0, 1'b0);
        send_beam(16'd65535, 20'sd0, 1'b0);
        send_beam(16'd300, 20'sd0, 1'b0);
        send_beam(16'd400, 20'sd100, 1'b1);
        send_beam(16'd50000, -20'sd524288, 1'b1);
        send_beam(16'd5000, 20'sd524287, 1'b1);
        send_beam(16'd3000, 20'sd0, 1'b0);
        send_beam(16'd3000, 20'sd0, 1'b1);
        drain();
        write_reg(CFG_LOOK_AHEAD, 141200);
        write_reg(CFG_RANGE_HIGH, 0);
        send_beam(16'd700, 20'sd0, 1'b1);
        send_beam(16'd700, -20'sd5, 1'b1);
        drain();
        write_reg(CFG_RANGE_HIGH, 65535);
        write_reg(CFG_BLIND, 411775);
        send_beam(16'd700, 20'sd0, 1'b1);
        drain();
        write_reg(CFG_BLIND, 0);
        write_reg(CFG_SAFETY, 65535);
        write_reg(CFG_START, -524288);
        write_reg(CFG_STEP, 65535);
        repeat (4) send_beam(16'd900, 20'sd0, 1'b0);
        send_beam(16'd900, 20'sd0, 1'b1);
        drain();
        write_reg(CFG_START, 524287);
        write_reg(CFG_RANGE_LOW, 65535);
        send_beam(16'd65535, 20'sd0, 1'b1);
        drain();
    endtask

    task automatic random_scans(int beams);
        int n;
        n = 0;
        while (n < beams) begin
            int len;
            len = $urandom_range(12) + 1;
            if ($urandom_range(9) == 0) len = 0;
            for (int b = 0; b < len; b++) begin
                logic [15:0] r;
                case ($urandom_range(3))
                    0: r = 16'($urandom);
                    1: r = 16'($urandom_range(cfg.safety_radius + 1));
                    default: r = 16'($urandom_range(6000));
                endcase
                send_beam(r, rand_off(), 1'b0);
            end
            send_beam(16'($urandom_range(6000)), rand_off(), 1'b1);
            n += len + 1;
        end
        drain();
    endtask

    task automatic random_settings();
        write_reg(CFG_BLIND, $urandom_range(3) == 0 ? $urandom_range(411775) :
            $urandom_range(60000));
        write_reg(CFG_RANGE_LOW, $urandom_range(300));
        write_reg(CFG_RANGE_HIGH, $urandom_range(1) ? 65535 : $urandom_range(65535));
        write_reg(CFG_SAFETY, $urandom_range(3) == 0 ? $urandom : $urandom_range(3000));
        write_reg(CFG_LOOK_AHEAD, $urandom_range(141200));
        write_reg(CFG_START, $urandom);
        write_reg(CFG_STEP, $urandom_range(1) ? $urandom_range(2000) : $urandom);
    endtask

    task automatic test_idle_mix();
        int pct[4][2] = '{'{0, 0}, '{69, 0}, '{0, 69}, '{32, 32}};
        for (int p = 0; p < 4; p++) begin
            send_idle_pct = pct[p][0];
            recv_stall_pct = pct[p][1];
            random_settings();
            random_scans(190);
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        hold_recv = 1'b1;
        fork
            begin
                repeat (3000) @(negedge i_clk);
                hold_recv = 1'b0;
            end
            begin
                for (int s = 0; s < 6; s++) begin
                    send_beam(16'd800, 20'sd0, 1'b0);
                    send_beam(16'd1500, 20'sd0, 1'b1);
                end
            end
        join
        drain();
    endtask

    initial begin
        clear_model();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_idle_mix();
        test_backpressure();
        drain();
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
`default_nettype wire
